>>> hdl/dorba_pkg.sv
package dorba_pkg;

  localparam int THR_W = 8;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd3;

  localparam int COUNT_W = 3;
  localparam logic [COUNT_W-1:0] CYCLE_LAST_TAKE = 3'd4;

  typedef enum logic {
    PH_IDLE,
    PH_UPD
  } phase_t;

  typedef struct packed {
    logic load;
    logic update;
  } lane_ctl_t;

endpackage

>>> hdl/dual_outlier_rejecting_block_average.sv
// items are taken only in the idle phase, so a new item waits until the
// last one has left the update phase; each lane registers its running mean
// on acceptance and updates sum, count and average in the update phase;
// the update phase waits while the output register holds an untaken item
// reset (synchronous, rst_n low): sums, counts, averages cleared,
// threshold set to 3, output empty
module dual_outlier_rejecting_block_average #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // left_sample, right_sample
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // average_sum, average_difference
  output logic [((2*(SAMPLE_BITS+2)+7)/8)*8-1:0] out_tdata,
  input  logic                                   cfg_we,
  input  logic [dorba_pkg::THR_W-1:0]            cfg_wdata
);
  import dorba_pkg::*;

  localparam int OW    = SAMPLE_BITS + 2;
  localparam int OUT_W = ((2*OW+7)/8)*8;

  logic [THR_W-1:0]       thr_r;
  phase_t                 phase_r, phase_nxt;
  lane_ctl_t              ctl;
  logic                   can_push;
  logic [SAMPLE_BITS:0]   left_avg, right_avg;
  logic [OW-1:0]          average_sum;
  logic signed [OW-1:0]   average_difference;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    in_tready  = 1'b0;
    ctl.load   = 1'b0;
    ctl.update = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        in_tready = 1'b1;
        ctl.load  = in_tvalid;
        if (in_tvalid) begin
          phase_nxt = PH_UPD;
        end
      end
      PH_UPD: begin
        ctl.update = can_push;
        if (can_push) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  dorba_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sample      (in_tdata[SAMPLE_BITS-1:0]),
    .threshold   (thr_r),
    .average_nxt (left_avg)
  );

  dorba_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .sample      (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .threshold   (thr_r),
    .average_nxt (right_avg)
  );

  dorba_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (ctl.update),
    .left_avg           (left_avg),
    .right_avg          (right_avg),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .average_sum        (average_sum),
    .average_difference (average_difference),
    .can_push           (can_push)
  );

  assign out_tdata = OUT_W'({average_difference, average_sum});

endmodule

>>> hdl/dorba_lane.sv
module dorba_lane #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  dorba_pkg::lane_ctl_t           ctl,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic [dorba_pkg::THR_W-1:0]    threshold,
  output logic [SAMPLE_BITS:0]           average_nxt
);
  import dorba_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + 3;
  // odd shift keeps the reciprocal exact for every sum below 2^K
  localparam int RK     = ((SUM_W + 1) % 2 == 1) ? SUM_W + 1 : SUM_W + 2;
  localparam int PROD_W = SUM_W + RK;
  localparam logic [RK-1:0] RECIP = RK'(((64'd1 << RK) + 64'd1) / 64'd3);

  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic [SAMPLE_BITS:0]   average_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] mean_r, mean_nxt;

  logic [PROD_W-1:0]      prod;
  logic [SUM_W-1:0]       quot;
  logic [SAMPLE_BITS-1:0] gap;
  logic [SAMPLE_BITS-1:0] addend;
  logic                   take_last;

  // running mean, count is one to four when it matters
  assign prod = PROD_W'(sum_r) * PROD_W'(RECIP);

  always_comb begin
    case (count_r)
      3'd1:    quot = sum_r;
      3'd2:    quot = sum_r >> 1;
      3'd3:    quot = prod[RK +: SUM_W];
      3'd4:    quot = sum_r >> 2;
      default: quot = '0;
    endcase
    mean_nxt = quot[SAMPLE_BITS-1:0];
  end

  always_comb begin
    gap = (mean_r >= sample_r) ? (mean_r - sample_r) : (sample_r - mean_r);
    if (count_r == '0) begin
      addend = sample_r;
    end else if (gap < SAMPLE_BITS'(threshold)) begin
      addend = sample_r;
    end else begin
      addend = mean_r;
    end
    take_last = (count_r > CYCLE_LAST_TAKE);
    if (take_last) begin
      sum_nxt   = '0;
      count_nxt = '0;
    end else begin
      sum_nxt   = sum_r + SUM_W'(addend);
      count_nxt = count_r + COUNT_W'(1);
    end
    average_nxt = (ctl.update && take_last) ? sum_r[SUM_W-1:2] : average_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      count_r   <= '0;
      average_r <= '0;
    end else if (ctl.update) begin
      sum_r     <= sum_nxt;
      count_r   <= count_nxt;
      average_r <= average_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample_r <= sample;
      mean_r   <= mean_nxt;
    end
  end

endmodule

>>> hdl/dorba_merge.sv
module dorba_merge #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [SAMPLE_BITS:0]        left_avg,
  input  logic [SAMPLE_BITS:0]        right_avg,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [SAMPLE_BITS+1:0]      average_sum,
  output logic signed [SAMPLE_BITS+1:0] average_difference,
  output logic                        can_push
);

  localparam int OW = SAMPLE_BITS + 2;

  logic                 valid_r;
  logic [OW-1:0]        sum_r;
  logic signed [OW-1:0] diff_r;

  assign can_push = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      sum_r  <= OW'(left_avg) + OW'(right_avg);
      diff_r <= signed'(OW'(left_avg) - OW'(right_avg));
    end
  end

  assign out_tvalid         = valid_r;
  assign average_sum        = sum_r;
  assign average_difference = diff_r;

endmodule

>>> verif/tb.sv
module tb;

  localparam int SB      = 12;
  localparam int IN_W    = ((2*SB+7)/8)*8;
  localparam int OUT_W   = ((2*(SB+2)+7)/8)*8;
  localparam int RES_W   = SB + 2;
  localparam int WD_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    int unsigned sum;
    int unsigned count;
    int unsigned average;
  } lane_t;

  typedef struct {
    logic [RES_W-1:0] total;
    logic [RES_W-1:0] diff;
  } average_pair_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  // left_sample, right_sample
  logic [IN_W-1:0]             in_tdata;
  logic                        out_tvalid;
  logic                        out_tready;
  // average_sum, average_difference
  logic [OUT_W-1:0]            out_tdata;
  logic                        cfg_we;
  logic [dorba_pkg::THR_W-1:0] cfg_wdata;

  lane_t                       left_lane;
  lane_t                       right_lane;
  int unsigned                 threshold;
  average_pair_t               predicted_averages[$];
  int                          errors;
  bit                          calm;
  bit                          hold_req;
  int                          hold_cnt;
  int                          idle_cycles;

  dual_outlier_rejecting_block_average #(
    .SAMPLE_BITS(SB)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one six-tick cycle step of a lane
  function automatic void advance_lane(inout lane_t ln, input int unsigned s);
    int unsigned mean;
    int unsigned gap;
    if (ln.count <= dorba_pkg::CYCLE_LAST_TAKE) begin
      if (ln.count == 0) begin
        ln.sum = ln.sum + s;
      end else begin
        mean = ln.sum / ln.count;
        gap = (mean >= s) ? mean - s : s - mean;
        if (gap < threshold) ln.sum = ln.sum + s;
        else ln.sum = ln.sum + mean;
      end
      ln.count = ln.count + 1;
    end else begin
      ln.average = ln.sum / 4;
      ln.count = 0;
      ln.sum = 0;
    end
    ln.sum = ln.sum & 32'h7FFF;
  endfunction

  function automatic void predict_averages(input logic [SB-1:0] l, input logic [SB-1:0] r);
    average_pair_t e;
    advance_lane(left_lane, l);
    advance_lane(right_lane, r);
    e.total = RES_W'(left_lane.average + right_lane.average);
    e.diff  = RES_W'(left_lane.average - right_lane.average);
    predicted_averages.push_back(e);
  endfunction

  // mostly near the running mean, so both accept and reject paths get hit
  function automatic logic [SB-1:0] pick_sample(input lane_t ln);
    int mean;
    int s;
    if ($urandom_range(0, 99) < 20 || ln.count == 0 || ln.count > dorba_pkg::CYCLE_LAST_TAKE)
      return SB'($urandom);
    mean = ln.sum / ln.count;
    s = mean + int'($urandom_range(0, 2*threshold + 2)) - int'(threshold + 1);
    if (s < 0) s = 0;
    if (s > (1 << SB) - 1) s = (1 << SB) - 1;
    return SB'(s);
  endfunction

  task automatic check_averages(input logic [OUT_W-1:0] d);
    average_pair_t e;
    if (predicted_averages.size() == 0) begin
      $display("%0t: unexpected item sum=%0d diff=%0d", $time, d[RES_W-1:0],
               $signed(d[2*RES_W-1:RES_W]));
      errors++;
      return;
    end
    e = predicted_averages.pop_front();
    if (d[RES_W-1:0] !== e.total) begin
      $display("%0t: average_sum expected %0d got %0d", $time, e.total, d[RES_W-1:0]);
      errors++;
    end
    if (d[2*RES_W-1:RES_W] !== e.diff) begin
      $display("%0t: average_difference expected %0d got %0d", $time, $signed(e.diff),
               $signed(d[2*RES_W-1:RES_W]));
      errors++;
    end
  endtask

  // result side: check, then random stalls or a counted hold-off
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_averages(out_tdata);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WD_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_pair(input logic [SB-1:0] l, input logic [SB-1:0] r);
    if (!calm && $urandom_range(0, 99) < 16) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, l};
    do @(posedge clk); while (!in_tready);
    predict_averages(l, r);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (predicted_averages.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input int unsigned v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= dorba_pkg::THR_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    threshold = v;
  endtask

  // rails, alternating bit patterns, accept and reject at the reset threshold
  task automatic test_extremes();
    send_pair(12'hFFF, 12'h000);
    send_pair(12'hFFE, 12'h001);
    send_pair(12'h000, 12'hFFF);
    send_pair(12'hFFD, 12'h002);
    send_pair(12'hFFC, 12'h000);
    send_pair(12'hAAA, 12'h555);
    send_pair(12'h555, 12'hAAA);
    send_pair(12'h557, 12'hAA8);
    send_pair(12'h558, 12'hAAA);
    send_pair(12'hFFF, 12'h000);
    send_pair(12'h556, 12'hAAB);
    send_pair(12'h000, 12'hFFF);
  endtask

  // nothing accepted on ticks 1 to 4, even an exact match
  task automatic test_zero_threshold();
    write_threshold(0);
    send_pair(12'd1000, 12'd4095);
    send_pair(12'd1000, 12'd4094);
    send_pair(12'd1001, 12'd0);
    send_pair(12'd1000, 12'd4095);
    send_pair(12'd999,  12'd4095);
    send_pair(12'd0,    12'd0);
  endtask

  task automatic test_wide_threshold();
    write_threshold(255);
    send_pair(12'd2000, 12'd100);
    send_pair(12'd2254, 12'd355);
    send_pair(12'd1872, 12'd0);
    send_pair(12'd1800, 12'd450);
    send_pair(12'd2300, 12'd4095);
    send_pair(12'hFFF,  12'hFFF);
  endtask

  task automatic test_random(input int unsigned thr, input int n);
    write_threshold(thr);
    repeat (n) send_pair(pick_sample(left_lane), pick_sample(right_lane));
  endtask

  // block fills up and stalls its input while the result side holds off
  task automatic test_output_stall();
    write_threshold($urandom_range(1, 255));
    hold_req = 1'b1;
    repeat (60) send_pair(pick_sample(left_lane), pick_sample(right_lane));
  endtask

  task automatic test_sender_pause();
    repeat (40) send_pair(pick_sample(left_lane), pick_sample(right_lane));
    in_tvalid <= 1'b0;
    while (predicted_averages.size() != 0) @(posedge clk);
    repeat (40) send_pair(pick_sample(left_lane), pick_sample(right_lane));
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    errors    = 0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    hold_cnt  = 0;
    left_lane  = '{0, 0, 0};
    right_lane = '{0, 0, 0};
    threshold  = dorba_pkg::THRESHOLD_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_zero_threshold();
    test_wide_threshold();
    test_random(1, 230);
    test_random(255, 230);
    test_random($urandom_range(2, 254), 230);
    calm = 1'b1;
    test_random(3, 230);
    calm = 1'b0;
    test_random($urandom_range(1, 40), 230);
    test_output_stall();
    test_sender_pause();

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/dorba_pkg.sv
hdl/dorba_lane.sv
hdl/dorba_merge.sv
hdl/dual_outlier_rejecting_block_average.sv
verif/tb.sv
